/* rtl/slv_pkg.sv */
// ----------------------------------------------------------------------------
// slv_pkg
// widths and types shared by the 3x3 cramer solver pipeline
// ----------------------------------------------------------------------------
package slv_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	// cofactor: difference of two full products
	localparam int COF_W  = 2 * DATA_WIDTH + 1;
	// split cofactor product: element times low or high cofactor part
	localparam int PP_W   = 2 * DATA_WIDTH + 1;
	// determinant and numerators, with headroom for the three-term sum
	localparam int DET_W  = 3 * DATA_WIDTH + 3;
	// quotient bits, top bit flags a quotient far out of range
	localparam int QW     = DATA_WIDTH + 2;
	localparam int AD_W   = DET_W + 1;
	localparam int AN_W   = DET_W + FRAC_BITS + 2;
	localparam int CMP_W  = AD_W + QW;

	typedef logic signed [DATA_WIDTH-1:0] elem_t;
	typedef logic signed [COF_W-1:0]      cof_t;
	typedef logic signed [PP_W-1:0]       pp_t;
	typedef logic signed [DET_W-1:0]      det_t;
	typedef logic        [QW-1:0]         quo_t;

	typedef struct packed {
		logic en;
		logic vld;
	} pipe_ctl_t;

endpackage

/* rtl/slv_cof.sv */
// ----------------------------------------------------------------------------
// slv_cof
// two stages: minor products, then the nine cofactors of the matrix
// ----------------------------------------------------------------------------
module slv_cof
	import slv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  pipe_ctl_t ctl,
	input  elem_t     a [9],
	input  elem_t     b [3],
	output logic      out_vld,
	output cof_t      cof [9],
	output elem_t     coef [6]
);

	// operand indexes of each cofactor: a[i0]*a[i1] - a[i2]*a[i3]
	localparam int CI [9][4] = '{
		'{4, 8, 5, 7}, '{5, 6, 3, 8}, '{3, 7, 4, 6},
		'{2, 7, 1, 8}, '{0, 8, 2, 6}, '{1, 6, 0, 7},
		'{1, 5, 2, 4}, '{2, 3, 0, 5}, '{0, 4, 1, 3}
	};

	logic                               vld_s1, vld_s2;
	logic signed [2*DATA_WIDTH-1:0]     pa_s1 [9];
	logic signed [2*DATA_WIDTH-1:0]     pb_s1 [9];
	elem_t                              coef_s1 [6];
	cof_t                               cof_s2 [9];
	elem_t                              coef_s2 [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (ctl.en) begin
			vld_s1 <= ctl.vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int k = 0; k < 9; k++) begin
				pa_s1[k]  <= a[CI[k][0]] * a[CI[k][1]];
				pb_s1[k]  <= a[CI[k][2]] * a[CI[k][3]];
				cof_s2[k] <= COF_W'(pa_s1[k]) - COF_W'(pb_s1[k]);
			end
			for (int k = 0; k < 3; k++) begin
				coef_s1[k]     <= a[k];
				coef_s1[k + 3] <= b[k];
			end
			coef_s2 <= coef_s1;
		end
	end

	assign out_vld = vld_s2;
	assign cof     = cof_s2;
	assign coef    = coef_s2;

endmodule

/* rtl/slv_dot.sv */
// ----------------------------------------------------------------------------
// slv_dot
// determinant and cramer numerators as dot products with cofactors
// ----------------------------------------------------------------------------
module slv_dot
	import slv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  pipe_ctl_t ctl,
	input  cof_t      cof [9],
	input  elem_t     coef [6],
	output logic      out_vld,
	output det_t      det [4]
);

	// sum 0 is the determinant, sum 1+i the numerator of x_i
	logic  vld_s3, vld_s4, vld_s5;
	pp_t   pl_s3 [4][3];
	pp_t   ph_s3 [4][3];
	det_t  term_s4 [4][3];
	det_t  det_s5 [4];

	elem_t op_x [4][3];
	cof_t  op_c [4][3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			op_x[0][k] = coef[k];
			op_c[0][k] = cof[k];
			for (int i = 0; i < 3; i++) begin
				op_x[i + 1][k] = coef[k + 3];
				op_c[i + 1][k] = cof[k * 3 + i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (ctl.en) begin
			vld_s3 <= ctl.vld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// cofactor split into an unsigned low half and a signed high part
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int j = 0; j < 4; j++) begin
				for (int k = 0; k < 3; k++) begin
					pl_s3[j][k] <= PP_W'(op_x[j][k]
						* $signed({1'b0, op_c[j][k][DATA_WIDTH-1:0]}));
					ph_s3[j][k] <= PP_W'(op_x[j][k]
						* $signed(op_c[j][k][COF_W-1:DATA_WIDTH]));
					term_s4[j][k] <= (DET_W'(ph_s3[j][k]) <<< DATA_WIDTH)
						+ DET_W'(pl_s3[j][k]);
				end
				det_s5[j] <= term_s4[j][0] + term_s4[j][1] + term_s4[j][2];
			end
		end
	end

	assign out_vld = vld_s5;
	assign det     = det_s5;

endmodule

/* rtl/slv_div.sv */
// ----------------------------------------------------------------------------
// slv_div
// three-lane restoring divider, one quotient bit per stage, with rounding
// and saturation to the output range
// ----------------------------------------------------------------------------
module slv_div
	import slv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  pipe_ctl_t ctl,
	input  det_t      det [4],
	output logic      out_vld,
	output elem_t     x [3],
	output logic      singular,
	output logic      overflow
);

	localparam int NST = QW;

	logic              vld_s [0:NST];
	logic              zero_s [0:NST];
	logic [AD_W-1:0]   ad_s [0:NST];
	logic              neg_s [0:NST][3];
	logic [CMP_W-1:0]  rem_s [0:NST][3];
	quo_t              q_s [0:NST][3];

	logic              vld_so;
	elem_t             x_so [3];
	logic              sing_so;
	logic              ovf_so;

	logic [DET_W-1:0]  abs_d;
	logic [DET_W-1:0]  abs_n [3];

	always_comb begin
		abs_d = det[0][DET_W-1] ? DET_W'(-det[0]) : DET_W'(det[0]);
		for (int i = 0; i < 3; i++)
			abs_n[i] = det[i + 1][DET_W-1] ? DET_W'(-det[i + 1]) : DET_W'(det[i + 1]);
	end

	// prep: rounding offset folded in as (2|n|*2^f + |d|) / (2|d|)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (ctl.en) begin
			vld_s[0] <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			zero_s[0] <= (det[0] == '0);
			ad_s[0]   <= {abs_d, 1'b0};
			for (int i = 0; i < 3; i++) begin
				neg_s[0][i] <= det[i + 1][DET_W-1] ^ det[0][DET_W-1];
				rem_s[0][i] <= CMP_W'((AN_W'(abs_n[i]) << (FRAC_BITS + 1)) + AN_W'(abs_d));
				q_s[0][i]   <= '0;
			end
		end
	end

	for (genvar t = 1; t <= NST; t++) begin : g_step
		localparam int SH = NST - t;
		logic [CMP_W-1:0] dsh;
		logic             ge [3];

		always_comb begin
			dsh = CMP_W'(ad_s[t-1]) << SH;
			for (int i = 0; i < 3; i++)
				ge[i] = rem_s[t-1][i] >= dsh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[t] <= 1'b0;
			end else if (ctl.en) begin
				vld_s[t] <= vld_s[t-1];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				zero_s[t] <= zero_s[t-1];
				ad_s[t]   <= ad_s[t-1];
				for (int i = 0; i < 3; i++) begin
					neg_s[t][i] <= neg_s[t-1][i];
					rem_s[t][i] <= ge[i] ? rem_s[t-1][i] - dsh : rem_s[t-1][i];
					q_s[t][i]   <= q_s[t-1][i] | (QW'(ge[i]) << SH);
				end
			end
		end
	end

	// saturation and sign
	quo_t        lim [3];
	logic        sat [3];
	quo_t        mag [3];
	elem_t       val [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lim[i] = neg_s[NST][i] ? (QW'(1) << (DATA_WIDTH - 1))
				: (QW'(1) << (DATA_WIDTH - 1)) - QW'(1);
			sat[i] = q_s[NST][i] > lim[i];
			mag[i] = sat[i] ? lim[i] : q_s[NST][i];
			val[i] = neg_s[NST][i] ? elem_t'(-mag[i][DATA_WIDTH-1:0])
				: elem_t'(mag[i][DATA_WIDTH-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_so <= 1'b0;
		end else if (ctl.en) begin
			vld_so <= vld_s[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			sing_so <= zero_s[NST];
			ovf_so  <= !zero_s[NST] && (sat[0] || sat[1] || sat[2]);
			for (int i = 0; i < 3; i++)
				x_so[i] <= zero_s[NST] ? '0 : val[i];
		end
	end

	assign out_vld  = vld_so;
	assign x        = x_so;
	assign singular = sing_so;
	assign overflow = ovf_so;

endmodule

/* rtl/solve_3x3_linear_system.sv */
// ----------------------------------------------------------------------------
// solve_3x3_linear_system
// pipelined cramer's rule solver for one 3x3 system a x = b per word
// ----------------------------------------------------------------------------
//
// channel   dir  contents
// s_*       in   a00..a22 (row major), b0..b2, signed q16.16, 32 bits each
// m_*       out  x0, x1, x2 signed q16.16; tuser singular, overflow
//
// one word enters per clock unless m_tready stalls the pipe; the stages are
// 2 cofactor, 3 dot-product, 1 divider prep, 34 quotient-bit, 1 output stage
// the quotient-bit stages of the restoring divider set the depth
// reset clears only the valid bits; no clearing pass, ready right away
// a stall at m_tready freezes every stage at once; s_tready follows it,
// so nothing is dropped or repeated
//
module solve_3x3_linear_system
	import slv_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// a00, a01, a02, a10, a11, a12, a20, a21, a22, b0, b1, b2 (32 bits each)
	input  logic [12*DATA_WIDTH-1:0] s_tdata,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// x0, x1, x2 (32 bits each)
	output logic [3*DATA_WIDTH-1:0] m_tdata,
	// singular, overflow
	output logic [1:0]              m_tuser
);

	logic      en;
	pipe_ctl_t ctl_in, ctl_dot, ctl_div;
	elem_t     a [9];
	elem_t     b [3];
	logic      cof_vld, dot_vld;
	cof_t      cof [9];
	elem_t     coef [6];
	det_t      det [4];
	elem_t     x [3];
	logic      singular, overflow;

	// whole pipeline moves when the output stage is empty or being taken
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// unpack the input word
	always_comb begin
		for (int k = 0; k < 9; k++)
			a[k] = elem_t'(s_tdata[k*DATA_WIDTH +: DATA_WIDTH]);
		for (int k = 0; k < 3; k++)
			b[k] = elem_t'(s_tdata[(k+9)*DATA_WIDTH +: DATA_WIDTH]);
	end

	assign ctl_in  = '{en: en, vld: s_tvalid};
	assign ctl_dot = '{en: en, vld: cof_vld};
	assign ctl_div = '{en: en, vld: dot_vld};

	// cofactors of a
	slv_cof u_cof (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_in),
		.a       (a),
		.b       (b),
		.out_vld (cof_vld),
		.cof     (cof),
		.coef    (coef)
	);

	// determinant and numerators
	slv_dot u_dot (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_dot),
		.cof     (cof),
		.coef    (coef),
		.out_vld (dot_vld),
		.det     (det)
	);

	// rounded, saturated quotients; last stage is the output register
	slv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_div),
		.det      (det),
		.out_vld  (m_tvalid),
		.x        (x),
		.singular (singular),
		.overflow (overflow)
	);

	assign m_tdata = {x[2], x[1], x[0]};
	assign m_tuser = {overflow, singular};

endmodule

/* bench/solve_3x3_linear_system_tb.sv */
// ----------------------------------------------------------------------------
// solve_3x3_linear_system_tb
// self-checking bench: streams 3x3 systems into the solver, predicts each
// solution with exact wide integer arithmetic and compares every output word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module solve_3x3_linear_system_tb;
	import slv_pkg::*;

	localparam int N_RANDOM   = 850;
	localparam int IDLE_LIMIT = 4000;

	// wide enough for any cofactor sum shifted by the fraction bits
	typedef logic signed [191:0] wide_t;
	typedef wide_t               mat_t [9];
	typedef logic [12*DATA_WIDTH-1:0] sys_t;

	typedef struct packed {
		elem_t x0;
		elem_t x1;
		elem_t x2;
		logic  singular;
		logic  overflow;
	} soln_t;

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [12*DATA_WIDTH-1:0] s_tdata;
	logic                    m_tvalid;
	logic                    m_tready;
	logic [3*DATA_WIDTH-1:0] m_tdata;
	logic [1:0]              m_tuser;

	sys_t  pending_sys[$];
	bit    pending_drain[$];
	soln_t expected_soln[$];

	int  errors;
	int  n_singular;
	int  n_overflow;
	int  n_solved;
	int  idle_cycles;
	int  src_gap;
	int  sink_gap;
	bit  src_burst;
	bit  sink_burst;
	bit  stim_done;

	solve_3x3_linear_system u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------------

	function automatic wide_t det_of(mat_t m);
		return m[0] * (m[4] * m[8] - m[5] * m[7])
			- m[1] * (m[3] * m[8] - m[5] * m[6])
			+ m[2] * (m[3] * m[7] - m[4] * m[6]);
	endfunction

	// round half away from zero, then clamp to the element range
	function automatic elem_t scaled_quotient(wide_t num, wide_t den, inout logic ovf);
		logic [191:0] an;
		logic [191:0] ad;
		logic [191:0] q;
		logic [191:0] lim;
		logic         neg;
		begin
			neg = (num < 0) != (den < 0);
			an  = (num < 0) ? -num : num;
			ad  = (den < 0) ? -den : den;
			an  = (an << (FRAC_BITS + 1)) + ad;
			ad  = ad << 1;
			q   = an / ad;
			lim = neg ? (192'd1 << (DATA_WIDTH - 1)) : ((192'd1 << (DATA_WIDTH - 1)) - 1);
			if (q > lim) begin
				q   = lim;
				ovf = 1'b1;
			end
			if (neg)
				q = -q;
			return q[DATA_WIDTH-1:0];
		end
	endfunction

	function automatic soln_t solve_system(sys_t sys);
		mat_t  a;
		mat_t  col;
		wide_t rhs [3];
		wide_t det;
		soln_t res;
		logic  ovf;
		elem_t xs [3];
		begin
			for (int i = 0; i < 9; i++)
				a[i] = $signed(sys[i*DATA_WIDTH +: DATA_WIDTH]);
			for (int i = 0; i < 3; i++)
				rhs[i] = $signed(sys[(9+i)*DATA_WIDTH +: DATA_WIDTH]);
			det = det_of(a);
			res = '0;
			if (det == 0) begin
				res.singular = 1'b1;
				return res;
			end
			ovf = 1'b0;
			for (int c = 0; c < 3; c++) begin
				col = a;
				for (int r = 0; r < 3; r++)
					col[r*3+c] = rhs[r];
				xs[c] = scaled_quotient(det_of(col), det, ovf);
			end
			res.x0       = xs[0];
			res.x1       = xs[1];
			res.x2       = xs[2];
			res.overflow = ovf;
			return res;
		end
	endfunction

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	function automatic sys_t pack_sys(elem_t e [12]);
		sys_t s;
		for (int i = 0; i < 12; i++)
			s[i*DATA_WIDTH +: DATA_WIDTH] = e[i];
		return s;
	endfunction

	// mix of full-range, moderate and tiny values
	function automatic elem_t rand_elem(int mode);
		case (mode)
			0:       return $urandom;
			1:       return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
			default: return $signed($urandom_range(0, 16)) - 8;
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic add_sys(elem_t e [12]);
		pending_sys.push_back(pack_sys(e));
		pending_drain.push_back(1'b0);
	endtask

	task automatic add_diag(elem_t d0, elem_t d1, elem_t d2, elem_t r0, elem_t r1, elem_t r2);
		elem_t e [12];
		foreach (e[i]) e[i] = '0;
		e[0] = d0; e[4] = d1; e[8] = d2;
		e[9] = r0; e[10] = r1; e[11] = r2;
		add_sys(e);
	endtask

	task automatic add_random_sys();
		elem_t e [12];
		int    mode;
		int    kind;
		mode = $urandom_range(0, 2);
		kind = $urandom_range(0, 9);
		foreach (e[i]) e[i] = rand_elem(mode);
		// a row copied or a column zeroed to land on a zero determinant
		if (kind == 0) begin
			e[3] = e[0]; e[4] = e[1]; e[5] = e[2];
		end else if (kind == 1) begin
			e[2] = '0; e[5] = '0; e[8] = '0;
		end else if (kind == 2) begin
			// strong diagonal with tiny off-diagonal terms, well conditioned
			foreach (e[i]) if (i < 9) e[i] = rand_elem(2);
			e[0] = rand_elem(1); e[4] = rand_elem(1); e[8] = rand_elem(1);
			e[9] = rand_elem(0); e[10] = rand_elem(1); e[11] = rand_elem(1);
		end
		add_sys(e);
	endtask

	// ------------------------------------------------------------------------
	// directed and random stimulus
	// ------------------------------------------------------------------------
	initial begin
		elem_t e [12];
		localparam elem_t ONE  = 32'sh0001_0000;
		localparam elem_t EMAX = 32'sh7fff_ffff;
		localparam elem_t EMIN = 32'sh8000_0000;

		arst_n    = 1'b0;
		stim_done = 1'b0;

		// identity, solution equals the right-hand side
		add_diag(ONE, ONE, ONE, ONE, -ONE, EMAX);
		add_diag(ONE, ONE, ONE, EMIN, '0, 32'sh0003_8000);
		// all zero matrix is singular
		foreach (e[i]) e[i] = '0;
		e[9] = EMAX;
		add_sys(e);
		// all max and all min entries, both singular
		foreach (e[i]) e[i] = EMAX;
		add_sys(e);
		foreach (e[i]) e[i] = EMIN;
		add_sys(e);
		// tiny diagonal with huge rhs saturates high and low
		add_diag(32'sd1, 32'sd1, 32'sd1, EMAX, EMIN, 32'sd1);
		add_diag(-32'sd1, 32'sd1, 32'sd2, EMAX, EMAX, EMIN);
		// rounding ties: half an lsb goes away from zero
		add_diag(32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000, 32'sd1, -32'sd1, 32'sd3);
		add_diag(32'sh0002_0000, -32'sh0002_0000, 32'sh0006_0000, 32'sd3, 32'sd1, 32'sd3);
		// extremes on the diagonal, nearly exact results
		add_diag(EMAX, EMIN, EMAX, EMIN, EMAX, EMAX);
		add_diag(EMIN, EMIN, EMIN, EMIN, EMIN, EMIN);
		add_diag(-ONE, -ONE, -ONE, EMIN, EMAX, -ONE);
		// dense full matrix with extremes mixed in
		e = '{EMAX, EMIN, ONE, -ONE, EMAX, 32'sd5, EMIN, 32'sd7, EMAX, EMAX, EMIN, ONE};
		add_sys(e);
		e = '{ONE, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000, 32'sh0005_0000,
			32'sh0006_0000, 32'sh0007_0000, 32'sh0008_0000, 32'sh000a_0000,
			ONE, ONE, ONE};
		add_sys(e);

		for (int n = 0; n < N_RANDOM; n++) begin
			add_random_sys();
			// hold the source until the pipe has emptied, now and then
			if (n % 300 == 150)
				pending_drain[$] = 1'b1;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_sys.size() == 0);
		@(posedge clk);
		while (s_tvalid || expected_soln.size() != 0)
			@(posedge clk);
		stim_done = 1'b1;
		repeat (60) @(posedge clk);

		$display("solved %0d systems: %0d singular, %0d saturated",
			n_solved, n_singular, n_overflow);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// source driver: one system per word, random gaps between words
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid  <= 1'b0;
			s_tdata   <= '0;
			src_gap   <= 0;
			src_burst <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				expected_soln.push_back(solve_system(s_tdata));
			if (!s_tvalid || s_tready) begin
				if ($urandom_range(0, 199) == 0)
					src_burst <= ~src_burst;
				if (src_gap > 0) begin
					src_gap  <= src_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_sys.size() != 0 && pending_drain[0] &&
						(expected_soln.size() != 0 || (s_tvalid && s_tready))) begin
					// wait for every outstanding solution before going on
					s_tvalid <= 1'b0;
				end else if (pending_sys.size() != 0) begin
					s_tdata  <= pending_sys.pop_front();
					void'(pending_drain.pop_front());
					s_tvalid <= 1'b1;
					src_gap  <= src_burst ? 0 : pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// sink: random stalls and result check
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		soln_t want;
		soln_t got;
		if (!arst_n) begin
			m_tready   <= 1'b0;
			sink_gap   <= 0;
			sink_burst <= 1'b0;
		end else begin
			if ($urandom_range(0, 199) == 0)
				sink_burst <= ~sink_burst;
			if (sink_gap > 0) begin
				sink_gap <= sink_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				sink_gap <= sink_burst ? 0 : pick_gap();
			end

			if (m_tvalid && m_tready) begin
				got.x0       = m_tdata[0*DATA_WIDTH +: DATA_WIDTH];
				got.x1       = m_tdata[1*DATA_WIDTH +: DATA_WIDTH];
				got.x2       = m_tdata[2*DATA_WIDTH +: DATA_WIDTH];
				got.singular = m_tuser[0];
				got.overflow = m_tuser[1];
				if (expected_soln.size() == 0) begin
					$error("solution word with nothing expected");
					errors++;
				end else begin
					want = expected_soln.pop_front();
					n_solved++;
					n_singular += want.singular;
					n_overflow += want.overflow;
					if (got.x0 !== want.x0) begin
						$error("x0 expected %h got %h", want.x0, got.x0);
						errors++;
					end
					if (got.x1 !== want.x1) begin
						$error("x1 expected %h got %h", want.x1, got.x1);
						errors++;
					end
					if (got.x2 !== want.x2) begin
						$error("x2 expected %h got %h", want.x2, got.x2);
						errors++;
					end
					if (got.singular !== want.singular) begin
						$error("singular expected %b got %b", want.singular, got.singular);
						errors++;
					end
					if (got.overflow !== want.overflow) begin
						$error("overflow expected %b got %b", want.overflow, got.overflow);
						errors++;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: too long without any word moving on either side
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || stim_done || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		errors      = 0;
		n_singular  = 0;
		n_overflow  = 0;
		n_solved    = 0;
		idle_cycles = 0;
	end

endmodule

/* files.f */
rtl/slv_pkg.sv
rtl/slv_cof.sv
rtl/slv_dot.sv
rtl/slv_div.sv
rtl/solve_3x3_linear_system.sv
bench/solve_3x3_linear_system_tb.sv
